FILE: hw/rtl/icr_pkg.sv
package icr_pkg;

    // Datagram geometry
    localparam int unsigned CountW       = 16;
    localparam logic [CountW-1:0] MaxDatagram = 16'hFFFF;
    localparam logic [CountW-1:0] HdrLen      = 16'd8;
    localparam logic [CountW-1:0] V6QuotedHdr = 16'd40;
    localparam logic [3:0]        MinIhl      = 4'd5;
    localparam logic [3:0]        IhlMask     = 4'hF;

    // ICMP message types
    localparam logic [7:0] V4_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] V4_DEST_UNREACH = 8'd3;
    localparam logic [7:0] V4_TIME_EXCEED  = 8'd11;
    localparam logic [7:0] V6_ECHO_REPLY   = 8'd129;
    localparam logic [7:0] V6_DEST_UNREACH = 8'd1;
    localparam logic [7:0] V6_TIME_EXCEED  = 8'd3;

    // Configuration register indexes
    localparam logic CFG_IPV6_MODE    = 1'b0;
    localparam logic CFG_EXPECTED_SEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_SUCCESS         = 3'd0,
        ST_NET_UNREACH     = 3'd1,
        ST_HOST_UNREACH    = 3'd2,
        ST_PROTO_UNREACH   = 3'd3,
        ST_PORT_UNREACH    = 3'd4,
        ST_OTHER_UNREACH   = 3'd5,
        ST_TTL_EXPIRED     = 3'd6,
        ST_UNKNOWN         = 3'd7
    } icr_status_t;

    // One received byte beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } icr_beat_t;

    // One classification result
    typedef struct packed {
        logic [15:0] payload_length;
        icr_status_t status;
        logic        matches_res;
    } icr_result_t;

endpackage

FILE: hw/rtl/icr_in_stage.sv
module icr_in_stage
    import icr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  icr_beat_t in_beat,
    output logic      out_valid,
    input  logic      out_take,
    output icr_beat_t out_beat
);

    logic      valid_reg;
    logic      valid_next;
    icr_beat_t beat_reg;

    // Register is free when empty or being drained this cycle
    assign in_ready   = !valid_reg || out_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

FILE: hw/rtl/icr_parse.sv
module icr_parse
    import icr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [15:0] cfg_wdata,
    input  logic        beat_valid,
    output logic        beat_take,
    input  icr_beat_t   beat,
    output logic        res_valid,
    input  logic        res_ready,
    output icr_result_t res
);

    logic        ipv6_mode_reg;
    logic [15:0] expected_seq_reg;

    logic [CountW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]        msg_type_reg, msg_type_next;
    logic [7:0]        msg_code_reg, msg_code_next;
    logic [15:0]       own_seq_reg, own_seq_next;
    logic [3:0]        q_words_reg, q_words_next;
    logic [15:0]       q_seq_reg, q_seq_next;

    logic        out_valid_reg, out_valid_next;
    icr_result_t out_reg;
    icr_result_t result;

    logic              not_sat;
    logic [6:0]        seq_pos;
    logic [6:0]        seq_pos_lo;
    logic [6:0]        v4_need;
    logic [CountW-1:0] size;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv6_mode_reg    <= 1'b0;
            expected_seq_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_IPV6_MODE:    ipv6_mode_reg    <= cfg_wdata[0];
                CFG_EXPECTED_SEQ: expected_seq_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // A beat moves on unless it carries a result that cannot be placed
    assign beat_take = beat_valid && (!beat.last_byte || !out_valid_reg || res_ready);

    // Quoted sequence position: after the quoted header
    assign seq_pos    = ipv6_mode_reg ? 7'(HdrLen + V6QuotedHdr + 16'd6)
                                      : 7'(7'd14 + {1'b0, q_words_reg, 2'b00});
    assign seq_pos_lo = 7'(seq_pos + 7'd1);
    assign not_sat    = byte_count_reg != MaxDatagram;

    // Field capture for the current byte
    always_comb
    begin
        byte_count_next = byte_count_reg;
        msg_type_next   = msg_type_reg;
        msg_code_next   = msg_code_reg;
        own_seq_next    = own_seq_reg;
        q_words_next    = q_words_reg;
        q_seq_next      = q_seq_reg;
        if (not_sat)
        begin
            byte_count_next = byte_count_reg + 16'd1;
            if (byte_count_reg == 16'd0)
                msg_type_next = beat.data_byte;
            else if (byte_count_reg == 16'd1)
                msg_code_next = beat.data_byte;
            else if (byte_count_reg == 16'd6)
                own_seq_next = {beat.data_byte, own_seq_reg[7:0]};
            else if (byte_count_reg == 16'd7)
                own_seq_next = {own_seq_reg[15:8], beat.data_byte};
            else if (byte_count_reg == HdrLen)
                q_words_next = beat.data_byte[3:0] & IhlMask;
            if (byte_count_reg > HdrLen)
            begin
                if (byte_count_reg == {9'd0, seq_pos})
                    q_seq_next = {beat.data_byte, q_seq_reg[7:0]};
                else if (byte_count_reg == {9'd0, seq_pos_lo})
                    q_seq_next = {q_seq_reg[15:8], beat.data_byte};
            end
        end
    end

    // Classification from the updated fields
    assign size    = byte_count_next;
    assign v4_need = 7'(7'd16 + {1'b0, q_words_next, 2'b00});

    always_comb
    begin
        result.matches_res    = 1'b0;
        result.status         = ST_UNKNOWN;
        result.payload_length = (size > HdrLen) ? 16'(size - HdrLen) : 16'd0;
        if (size >= HdrLen)
        begin
            if (ipv6_mode_reg)
            begin
                if (msg_type_next == V6_ECHO_REPLY)
                    result.matches_res = own_seq_next == expected_seq_reg;
                else if (size >= HdrLen + V6QuotedHdr + HdrLen)
                    result.matches_res = q_seq_next == expected_seq_reg;
                case (msg_type_next)
                    V6_ECHO_REPLY:   result.status = ST_SUCCESS;
                    V6_DEST_UNREACH: result.status = ST_OTHER_UNREACH;
                    V6_TIME_EXCEED:  result.status = ST_TTL_EXPIRED;
                    default:         result.status = ST_UNKNOWN;
                endcase
            end
            else
            begin
                if (msg_type_next == V4_ECHO_REPLY)
                    result.matches_res = own_seq_next == expected_seq_reg;
                else if (size >= HdrLen + 16'd1 && q_words_next >= MinIhl
                         && size >= {9'd0, v4_need})
                    result.matches_res = q_seq_next == expected_seq_reg;
                case (msg_type_next)
                    V4_ECHO_REPLY:   result.status = ST_SUCCESS;
                    V4_DEST_UNREACH:
                    begin
                        if (msg_code_next <= 8'd3)
                            result.status = icr_status_t'(3'(msg_code_next[1:0] + 2'd1)
                                            | {msg_code_next[1] & msg_code_next[0], 2'b00});
                        else
                            result.status = ST_OTHER_UNREACH;
                    end
                    V4_TIME_EXCEED:  result.status = ST_TTL_EXPIRED;
                    default:         result.status = ST_UNKNOWN;
                endcase
            end
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !res_ready;
        if (beat_take && beat.last_byte)
            out_valid_next = 1'b1;
    end

    // Per-datagram state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            msg_type_reg   <= '0;
            msg_code_reg   <= '0;
            own_seq_reg    <= '0;
            q_words_reg    <= '0;
            q_seq_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (beat_take)
            begin
                if (beat.last_byte)
                begin
                    byte_count_reg <= '0;
                    msg_type_reg   <= '0;
                    msg_code_reg   <= '0;
                    own_seq_reg    <= '0;
                    q_words_reg    <= '0;
                    q_seq_reg      <= '0;
                end
                else
                begin
                    byte_count_reg <= byte_count_next;
                    msg_type_reg   <= msg_type_next;
                    msg_code_reg   <= msg_code_next;
                    own_seq_reg    <= own_seq_next;
                    q_words_reg    <= q_words_next;
                    q_seq_reg      <= q_seq_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take && beat.last_byte)
        begin
            out_reg <= result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Final byte produces a result and restarts the count
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        beat_take && beat.last_byte |=> out_valid_reg && byte_count_reg == '0)
        else $error("final byte did not load result or clear count");

    // Non-final bytes count up until saturation
    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        beat_take && !beat.last_byte && byte_count_reg != MaxDatagram
        |=> byte_count_reg == $past(byte_count_reg) + 16'd1)
        else $error("byte count did not advance");

    // A held result never disappears while stalled
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule

FILE: hw/rtl/icmp_reply_classifier_top.sv
// ICMP reply classifier: bytes of one ICMPv4 or ICMPv6 datagram enter on the
// slave stream, one per beat, starting at the ICMP header, with s_tlast on the
// final byte. Throughput is one byte per clock while no final byte waits; a
// byte passes an input register, then the field-capture and decision logic,
// and the result lands in a result register that drives the master stream. A
// final byte waits in the input register while the previous result is still
// held on the master stream; other bytes never wait. Only the final byte
// yields a result beat. Mode and expected sequence are written through the cfg
// port (index 0 ipv6_mode in bit 0, index 1 expected_sequence); the user must
// write them only while no datagram is in flight; the block does not check.
module icmp_reply_classifier_top
    import icr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // Datagram bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] matches_res, [3:1] status,
                                   // [19:4] payload_length, [23:20] zero
);

    icr_beat_t   in_beat;
    icr_beat_t   stage_beat;
    logic        stage_valid;
    logic        stage_take;
    icr_result_t res;

    assign cfg_ready = 1'b1;

    assign in_beat.data_byte = s_tdata;
    assign in_beat.last_byte = s_tlast;

    icr_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (in_beat),
        .out_valid (stage_valid),
        .out_take  (stage_take),
        .out_beat  (stage_beat)
    );

    icr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .beat_valid (stage_valid),
        .beat_take  (stage_take),
        .beat       (stage_beat),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // Result beat packing
    assign m_tdata = {4'd0, res.payload_length, res.status, res.matches_res};

endmodule

FILE: dv/tb.sv
module tb;
    import icr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit  = 600000;
    localparam int unsigned DrainCycles = 8;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_IPV6_MODE;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    icmp_reply_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Stimulus and scoreboard storage
    icr_beat_t   byte_backlog[$];
    icr_result_t pending_verdicts[$];
    logic [7:0]  dg_bytes[$];

    int unsigned beats_queued  = 0;
    int unsigned beats_taken   = 0;
    int unsigned cfg_writes    = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_idle_pct  = 0;
    bit          s_beat_taken  = 1'b0;

    // Classifier model state and settings
    bit          mode_v6  = 1'b0;
    logic [15:0] want_seq = 16'd0;
    logic [15:0] dg_count = 16'd0;
    logic [7:0]  dg_type  = 8'd0;
    logic [7:0]  dg_code  = 8'd0;
    logic [15:0] dg_own_seq    = 16'd0;
    logic [15:0] dg_quoted_seq = 16'd0;
    logic [3:0]  dg_ihl   = 4'd0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Take one datagram byte; returns 1 with the verdict on the final byte
    function automatic bit absorb_byte(input logic [7:0] b, input bit last,
                                       output icr_result_t verdict);
        int unsigned pos;
        int unsigned seq_at;
        int unsigned len;
        bit          hit;
        icr_status_t st;
        pos = dg_count;
        // capture stops once the count saturates
        if (dg_count != MaxDatagram)
        begin
            case (pos)
                0: dg_type = b;
                1: dg_code = b;
                6: dg_own_seq[15:8] = b;
                7: dg_own_seq[7:0] = b;
                8: dg_ihl = b[3:0] & IhlMask;
                default: ;
            endcase
            if (mode_v6)
                seq_at = HdrLen + V6QuotedHdr + 6;
            else
                seq_at = HdrLen + 4 * dg_ihl + 6;
            if (pos > HdrLen)
            begin
                if (pos == seq_at)
                    dg_quoted_seq[15:8] = b;
                else if (pos == seq_at + 1)
                    dg_quoted_seq[7:0] = b;
            end
            dg_count = dg_count + 16'd1;
        end
        if (!last)
            return 1'b0;

        len = dg_count;
        // sequence correlation
        hit = 1'b0;
        if (len >= HdrLen)
        begin
            if (mode_v6)
            begin
                if (dg_type == V6_ECHO_REPLY)
                    hit = (dg_own_seq == want_seq);
                else
                    hit = (len >= 2 * HdrLen + V6QuotedHdr) && (dg_quoted_seq == want_seq);
            end
            else if (dg_type == V4_ECHO_REPLY)
                hit = (dg_own_seq == want_seq);
            else
                hit = (len >= HdrLen + 1) && (dg_ihl >= MinIhl)
                      && (len >= 2 * HdrLen + 4 * dg_ihl) && (dg_quoted_seq == want_seq);
        end
        // status class
        if (len < HdrLen)
            st = ST_UNKNOWN;
        else if (mode_v6)
        begin
            case (dg_type)
                V6_ECHO_REPLY:   st = ST_SUCCESS;
                V6_DEST_UNREACH: st = ST_OTHER_UNREACH;
                V6_TIME_EXCEED:  st = ST_TTL_EXPIRED;
                default:         st = ST_UNKNOWN;
            endcase
        end
        else
        begin
            case (dg_type)
                V4_ECHO_REPLY: st = ST_SUCCESS;
                V4_DEST_UNREACH:
                begin
                    case (dg_code)
                        8'd0:    st = ST_NET_UNREACH;
                        8'd1:    st = ST_HOST_UNREACH;
                        8'd2:    st = ST_PROTO_UNREACH;
                        8'd3:    st = ST_PORT_UNREACH;
                        default: st = ST_OTHER_UNREACH;
                    endcase
                end
                V4_TIME_EXCEED: st = ST_TTL_EXPIRED;
                default:        st = ST_UNKNOWN;
            endcase
        end
        verdict.matches_res    = hit;
        verdict.status         = st;
        verdict.payload_length = (len > HdrLen) ? 16'(len - HdrLen) : 16'd0;

        dg_count      = 16'd0;
        dg_type       = 8'd0;
        dg_code       = 8'd0;
        dg_own_seq    = 16'd0;
        dg_quoted_seq = 16'd0;
        dg_ihl        = 4'd0;
        return 1'b1;
    endfunction

    // Sample handshakes, predict and check at the rising edge
    always @(posedge clk)
    begin : monitor
        icr_result_t verdict;
        icr_result_t got;
        cycle_count++;
        s_beat_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IPV6_MODE)
                    mode_v6 = cfg_data[0];
                else
                    want_seq = cfg_data;
                cfg_writes++;
            end
            s_beat_taken = s_tvalid && s_tready;
            if (s_beat_taken)
            begin
                beats_taken++;
                if (absorb_byte(s_tdata, s_tlast, verdict))
                    pending_verdicts.push_back(verdict);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[19:0];
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: result beat %h with no datagram outstanding", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    verdict = pending_verdicts.pop_front();
                    if (got.matches_res !== verdict.matches_res)
                    begin
                        $display("%0t: matches_res expected %0d, got %0d",
                                 $time, verdict.matches_res, got.matches_res);
                        mismatches++;
                    end
                    if (got.status !== verdict.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, verdict.status, got.status);
                        mismatches++;
                    end
                    if (got.payload_length !== verdict.payload_length)
                    begin
                        $display("%0t: payload_length expected %0d, got %0d",
                                 $time, verdict.payload_length, got.payload_length);
                        mismatches++;
                    end
                    if (m_tdata[23:20] !== 4'd0)
                    begin
                        $display("%0t: tdata pad expected 0, got %h", $time, m_tdata[23:20]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Byte driver: next beat or an idle cycle, changed at the falling edge
    always @(negedge clk)
    begin : byte_driver
        icr_beat_t beat;
        if (rst_n && (!s_tvalid || s_beat_taken))
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                beat = byte_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= beat.data_byte;
                s_tlast  <= beat.last_byte;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial
    begin : watchdog
        wait (cycle_count == CycleLimit);
        $display("Some tests failed");
        $finish;
    end

    // Queue the bytes in dg_bytes; close marks the final one
    task automatic ship(input bit close);
        icr_beat_t beat;
        for (int i = 0; i < dg_bytes.size(); i++)
        begin
            beat.data_byte = dg_bytes[i];
            beat.last_byte = close && (i == dg_bytes.size() - 1);
            byte_backlog.push_back(beat);
            beats_queued++;
        end
    endtask

    task automatic build_echo(input bit v6, input logic [15:0] seq, input int unsigned extra);
        dg_bytes = {};
        dg_bytes.push_back(v6 ? V6_ECHO_REPLY : V4_ECHO_REPLY);
        repeat (5) dg_bytes.push_back(8'($urandom));
        dg_bytes.push_back(seq[15:8]);
        dg_bytes.push_back(seq[7:0]);
        repeat (extra) dg_bytes.push_back(8'($urandom));
    endtask

    // Error message quoting the original echo request
    task automatic build_error(input bit v6, input logic [7:0] kind, input logic [7:0] code,
                               input logic [3:0] ihl, input logic [15:0] seq,
                               input int unsigned extra);
        dg_bytes = {};
        dg_bytes.push_back(kind);
        dg_bytes.push_back(code);
        repeat (6) dg_bytes.push_back(8'($urandom));
        if (v6)
        begin
            dg_bytes.push_back(8'h60);
            repeat (39) dg_bytes.push_back(8'($urandom));
        end
        else
        begin
            dg_bytes.push_back({4'h4, ihl});
            for (int i = 1; i < 4 * ihl; i++)
                dg_bytes.push_back(8'($urandom));
        end
        dg_bytes.push_back(v6 ? 8'd128 : 8'd8);
        repeat (5) dg_bytes.push_back(8'($urandom));
        dg_bytes.push_back(seq[15:8]);
        dg_bytes.push_back(seq[7:0]);
        repeat (extra) dg_bytes.push_back(8'($urandom));
    endtask

    task automatic build_random_error(input bit v6, input logic [15:0] seq);
        logic [7:0] kind;
        logic [7:0] code;
        logic [3:0] ihl;
        case ($urandom_range(2))
            0:       kind = v6 ? V6_DEST_UNREACH : V4_DEST_UNREACH;
            1:       kind = v6 ? V6_TIME_EXCEED : V4_TIME_EXCEED;
            default: kind = 8'($urandom);
        endcase
        code = ($urandom_range(3) != 0) ? 8'($urandom_range(5)) : 8'($urandom);
        ihl  = ($urandom_range(7) != 0) ? 4'($urandom_range(15, 5)) : 4'($urandom_range(4));
        build_error(v6, kind, code, ihl, seq, $urandom_range(8));
    endtask

    // Wait until every byte is in and every verdict is out, then let the pipe drain
    task automatic settle();
        while (beats_taken != beats_queued || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        int unsigned target;
        target = cfg_writes + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        wait (cfg_writes == target);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input bit v6, input logic [15:0] seq);
        settle();
        write_reg(CFG_IPV6_MODE, {15'd0, v6});
        write_reg(CFG_EXPECTED_SEQ, seq);
    endtask

    task automatic random_phase(input bit v6, input logic [15:0] seq, input int unsigned budget);
        int unsigned sent;
        int unsigned made;
        int unsigned sel;
        int unsigned cut;
        logic [15:0] s;
        configure(v6, seq);
        sent = 0;
        made = 0;
        while (sent < budget || made < 10)
        begin
            s   = $urandom_range(1) ? seq : 16'($urandom);
            sel = $urandom_range(99);
            if (sel < 30)
                build_echo(v6, s, $urandom_range(12));
            else if (sel < 70)
                build_random_error(v6, s);
            else if (sel < 85)
            begin
                // noise
                dg_bytes = {};
                repeat ($urandom_range(24, 1)) dg_bytes.push_back(8'($urandom));
            end
            else
            begin
                // well-formed start, cut short
                if ($urandom_range(1))
                    build_echo(v6, s, $urandom_range(12));
                else
                    build_random_error(v6, s);
                cut = $urandom_range(dg_bytes.size(), 1);
                dg_bytes = dg_bytes[0:cut-1];
            end
            sent += dg_bytes.size();
            made++;
            ship(1'b1);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] rest[$];
        snd_idle_pct = 13;
        rcv_idle_pct = 55;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Reset settings: ICMPv4, expected sequence zero
        build_echo(1'b0, 16'h0000, 0);
        ship(1'b1);
        build_echo(1'b0, 16'h0001, 4);
        ship(1'b1);
        // short datagrams
        dg_bytes = {8'h00};
        ship(1'b1);
        build_echo(1'b0, 16'h0000, 0);
        dg_bytes = dg_bytes[0:6];
        ship(1'b1);

        // ICMPv4 errors against the top sequence
        configure(1'b0, 16'hFFFF);
        for (int c = 0; c <= 4; c++)
        begin
            build_error(1'b0, V4_DEST_UNREACH, 8'(c), 4'd5, 16'hFFFF, 0);
            ship(1'b1);
        end
        build_error(1'b0, V4_DEST_UNREACH, 8'hFF, 4'd5, 16'hFFFF, 3);
        ship(1'b1);
        build_error(1'b0, V4_TIME_EXCEED, 8'd0, 4'd15, 16'hFFFF, 0);
        ship(1'b1);
        // quoted header too short
        build_error(1'b0, V4_TIME_EXCEED, 8'd0, 4'd4, 16'hFFFF, 0);
        ship(1'b1);
        // quoted request one byte short
        build_error(1'b0, V4_DEST_UNREACH, 8'd1, 4'd5, 16'hFFFF, 0);
        dg_bytes = dg_bytes[0:34];
        ship(1'b1);
        // only the header-length byte of the quote
        build_error(1'b0, V4_DEST_UNREACH, 8'd0, 4'd5, 16'hFFFF, 0);
        dg_bytes = dg_bytes[0:8];
        ship(1'b1);
        // unknown types
        build_error(1'b0, 8'd8, 8'd0, 4'd5, 16'hFFFF, 0);
        ship(1'b1);
        build_error(1'b0, 8'hFF, 8'hFF, 4'd5, 16'hFFFF, 0);
        ship(1'b1);
        build_echo(1'b0, 16'hFFFF, 2);
        ship(1'b1);
        build_echo(1'b0, 16'hFFFE, 0);
        ship(1'b1);

        // ICMPv6 message kinds
        configure(1'b1, 16'h1234);
        build_echo(1'b1, 16'h1234, 5);
        ship(1'b1);
        build_error(1'b1, V6_DEST_UNREACH, 8'd4, 4'd0, 16'h1234, 0);
        ship(1'b1);
        build_error(1'b1, V6_TIME_EXCEED, 8'd0, 4'd0, 16'h1234, 0);
        dg_bytes = dg_bytes[0:54];
        ship(1'b1);
        build_error(1'b1, 8'd128, 8'd0, 4'd0, 16'h1234, 2);
        ship(1'b1);
        build_echo(1'b1, 16'h1234, 1);
        dg_bytes[0] = V4_ECHO_REPLY;
        ship(1'b1);

        // Mode switched to ICMPv6 partway through a datagram
        configure(1'b0, 16'h1234);
        build_error(1'b1, V6_DEST_UNREACH, 8'd0, 4'd0, 16'h1234, 0);
        rest = dg_bytes[10:$];
        dg_bytes = dg_bytes[0:9];
        ship(1'b0);
        configure(1'b1, 16'h1234);
        dg_bytes = rest;
        ship(1'b1);
        // and back to ICMPv4 partway through
        build_error(1'b0, V4_DEST_UNREACH, 8'd3, 4'd5, 16'h1234, 0);
        rest = dg_bytes[20:$];
        dg_bytes = dg_bytes[0:19];
        ship(1'b0);
        configure(1'b0, 16'h1234);
        dg_bytes = rest;
        ship(1'b1);

        // Random traffic under three back-pressure regimes
        random_phase(1'b0, 16'hFFFF, 110);
        random_phase(1'b1, 16'h0000, 110);
        snd_idle_pct = 55;
        rcv_idle_pct = 13;
        random_phase(1'b0, 16'($urandom), 110);
        random_phase(1'b1, 16'hFFFF, 110);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_phase(1'b0, 16'($urandom), 110);
        random_phase(1'b1, 16'($urandom), 110);

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/icr_pkg.sv
hw/rtl/icr_in_stage.sv
hw/rtl/icr_parse.sv
hw/rtl/icmp_reply_classifier_top.sv
dv/tb.sv
